// ===== sv/sequential_list_engine_top_assert.svh =====
// assertion macros used by the sequential list engine checker
// no dependencies; each macro expects a signal named clk and arst_n in scope
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define SLE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sle check failed: same-cycle implication");

// next-cycle implication, disabled while reset is held
`define SLE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sle check failed: next-cycle implication");

`endif

// ===== sv/sle_pkg.sv =====
// shared action codes and cell control type for the sequential list engine
// no dependencies
`default_nettype none

package sle_pkg;

	// request kinds
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_LOCATE = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	// stream field widths
	localparam int ACTION_W = 2;
	localparam int POS_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int SMALL_W  = 7;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 48;

	// per-cell control for one accepted transaction
	typedef struct packed {
		logic load;        // take the inserted word
		logic from_left;   // shift up: take left neighbor
		logic from_right;  // shift down: take right neighbor
		logic pick;        // this cell is the one being read or deleted
		logic live;        // cell lies inside the current list
		logic sample;      // capture compare and pick results
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/sequential_list_engine_top.sv =====
// Ordered list of up to CAPACITY words held in a row of cells. A transaction
// is accepted at a clock edge, where the cells shift, compare and pick at once;
// the registered results go to the output register once it is empty or being
// drained. With the output drained, one transaction is accepted every cycle.
// The search result goes through a priority encoder over the registered match
// bits, which sets the critical path into the output register.
// depends on sle_pkg and sle_cell
`default_nettype none

module sequential_list_engine_top #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_axis_tvalid,
	output logic                        s_axis_tready,
	// action[1:0], position[8:2], value[40:9], zero fill above
	input  wire  [sle_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire                         m_axis_tready,
	// ok[0], element[32:1], found_at[39:33], count[46:40], zero fill above
	output logic [sle_pkg::OUT_W-1:0]   m_axis_tdata
);
	import sle_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

	// input field split
	logic [ACTION_W-1:0]   action;
	logic [POS_W-1:0]      position;
	logic [VALUE_W-1:0]    value;
	logic [DW+VALUE_W-1:0] val_ext;
	logic [DW-1:0]         key;

	assign action   = s_axis_tdata[ACTION_W-1:0];
	assign position = s_axis_tdata[ACTION_W+POS_W-1:ACTION_W];
	assign value    = s_axis_tdata[ACTION_W+POS_W+VALUE_W-1:ACTION_W+POS_W];
	assign val_ext  = {{DW{1'b0}}, value};
	assign key      = val_ext[DW-1:0];

	// control state
	logic [LW-1:0] len_q;
	logic          pend_q;
	logic          out_valid_q;
	logic          acc;
	logic          fin;

	assign fin           = pend_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !pend_q || fin;
	assign acc           = s_axis_tvalid && s_axis_tready;

	// position checks
	logic [CW-1:0] pos_w;
	logic [CW-1:0] len_w;
	logic [CW-1:0] p0;
	logic          is_ins;
	logic          is_del;
	logic          is_rd;
	logic          ins_ok;
	logic          rd_ok;
	logic          req_ok;

	assign pos_w  = CW'(position);
	assign len_w  = CW'(len_q);
	assign p0     = pos_w - CW'(1);
	assign is_ins = (action == ACT_INSERT);
	assign is_del = (action == ACT_DELETE);
	assign is_rd  = (action == ACT_READ);
	assign ins_ok = (pos_w != '0) && (pos_w <= len_w + CW'(1)) && (len_w < CW'(CAPACITY));
	assign rd_ok  = (pos_w != '0) && (pos_w <= len_w);

	always_comb begin
		unique case (action)
			ACT_INSERT: req_ok = ins_ok;
			ACT_DELETE: req_ok = rd_ok;
			ACT_LOCATE: req_ok = 1'b1;
			ACT_READ:   req_ok = rd_ok;
			default:    req_ok = 1'b0;
		endcase
	end

	// per-cell control
	cell_ctl_t ctl_w [CAPACITY];

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ctl_w[i].load       = acc && is_ins && ins_ok && (CW'(i) == p0);
			ctl_w[i].from_left  = acc && is_ins && ins_ok && (CW'(i) > p0);
			ctl_w[i].from_right = acc && is_del && rd_ok && (CW'(i) >= p0);
			ctl_w[i].pick       = (is_del || is_rd) && rd_ok && (CW'(i) == p0);
			ctl_w[i].live       = (CW'(i) < len_w);
			ctl_w[i].sample     = acc;
		end
	end

	// row of cells
	logic [DW-1:0] word_w [CAPACITY];
	logic [DW-1:0] pick_w [CAPACITY];
	logic          hit_w  [CAPACITY];

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DW-1:0] left_w;
		logic [DW-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = key;
		end else begin : g_mid_l
			assign left_w = word_w[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_w = word_w[g];
		end else begin : g_mid_r
			assign right_w = word_w[g+1];
		end

		sle_cell #(
			.DW(DW)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl_w[g]),
			.val     (key),
			.left    (left_w),
			.right   (right_w),
			.word    (word_w[g]),
			.hit_s1  (hit_w[g]),
			.pick_s1 (pick_w[g])
		);
	end

	// length and pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			if (acc && is_ins && ins_ok) begin
				len_q <= len_q + LW'(1);
			end else if (acc && is_del && rd_ok) begin
				len_q <= len_q - LW'(1);
			end
			if (acc) begin
				pend_q <= 1'b1;
			end else if (fin) begin
				pend_q <= 1'b0;
			end
		end
	end

	// request fields carried to the output register
	logic [ACTION_W-1:0] act_s1;
	logic                ok_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			act_s1 <= action;
			ok_s1  <= req_ok;
		end
	end

	// first match and picked word
	logic [LW-1:0] found_w;
	logic [DW-1:0] pick_or;

	always_comb begin
		found_w = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hit_w[i]) begin
				found_w = LW'(i + 1);
			end
		end
	end

	always_comb begin
		pick_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			pick_or = pick_or | pick_w[i];
		end
	end

	// output field sizing
	logic [DW+VALUE_W-1:0]  elem_ext;
	logic [LW+SMALL_W-1:0]  found_ext;
	logic [LW+SMALL_W-1:0]  count_ext;

	assign elem_ext  = {{VALUE_W{1'b0}}, pick_or};
	assign found_ext = {{SMALL_W{1'b0}}, ((act_s1 == ACT_LOCATE) ? found_w : LW'(0))};
	assign count_ext = {{SMALL_W{1'b0}}, len_q};

	// output register
	logic               ok_q;
	logic [VALUE_W-1:0] element_q;
	logic [SMALL_W-1:0] found_at_q;
	logic [SMALL_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			ok_q       <= ok_s1;
			element_q  <= elem_ext[VALUE_W-1:0];
			found_at_q <= found_ext[SMALL_W-1:0];
			count_q    <= count_ext[SMALL_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, count_q, found_at_q, element_q, ok_q};

endmodule

`default_nettype wire

// ===== sv/sle_cell.sv =====
// one list cell: holds a word, shifts with its neighbors, compares and picks
// depends on sle_pkg
`default_nettype none

module sle_cell #(
	parameter int DW = 32
) (
	input  wire                 clk,
	input  sle_pkg::cell_ctl_t  ctl,
	input  wire  [DW-1:0]       val,
	input  wire  [DW-1:0]       left,
	input  wire  [DW-1:0]       right,
	output logic [DW-1:0]       word,
	output logic                hit_s1,
	output logic [DW-1:0]       pick_s1
);
	import sle_pkg::*;

	logic [DW-1:0] word_q;

	// stored word: insert, shift up or shift down
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= val;
		end else if (ctl.from_left) begin
			word_q <= left;
		end else if (ctl.from_right) begin
			word_q <= right;
		end
	end

	// compare and pick against contents before the shift
	always_ff @(posedge clk) begin
		if (ctl.sample) begin
			hit_s1  <= ctl.live && (word_q == val);
			pick_s1 <= ctl.pick ? word_q : '0;
		end
	end

	assign word = word_q;

endmodule

`default_nettype wire

// ===== sv/sle_chk.sv =====
// port-level checks for the sequential list engine, bound to the top level
// depends on sequential_list_engine_top_assert.svh and sle_pkg
`default_nettype none

`include "sequential_list_engine_top_assert.svh"

module sle_chk (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         s_axis_tready,
	input wire                         m_axis_tvalid,
	input wire                         m_axis_tready,
	input wire [sle_pkg::OUT_W-1:0]    m_axis_tdata
);
	import sle_pkg::*;

	logic                res_ok;
	logic [VALUE_W-1:0]  res_elem;
	logic [SMALL_W-1:0]  res_found;

	assign res_ok    = m_axis_tdata[0];
	assign res_elem  = m_axis_tdata[VALUE_W:1];
	assign res_found = m_axis_tdata[VALUE_W+SMALL_W:VALUE_W+1];

	// a stalled result transaction holds its payload
	`SLE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// a failed request reports no element and no match
	`SLE_ASSERT_NOW(a_fail_clean, m_axis_tvalid && !res_ok, res_elem == '0 && res_found == '0)

	// a match only comes from a successful locate, which carries no element
	`SLE_ASSERT_NOW(a_found_clean, m_axis_tvalid && res_found != '0, res_ok && res_elem == '0)

	// the input side only stalls behind a result that is itself stalled
	`SLE_ASSERT_NOW(a_in_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind sequential_list_engine_top sle_chk u_sle_chk (.*);

`default_nettype wire
